// File: rtl/core/lmrt_pkg.sv
// Shared types and constants for the module recency tracker.
package lmrt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int SIZE_W   = 20;
  localparam int MEM_W    = 32;
  localparam int PCT_W    = 7;
  localparam int MODE_W   = 2;
  localparam int PROD_W   = MEM_W + PCT_W;

  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(85);
  localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_UNLOAD = 2'd1,
    MODE_TOUCH  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LEFT,
    OP_RIGHT,
    OP_NEW
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_QUERY
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: rtl/core/lmrt_cell.sv
// One slot of the recency chain: holds an entry, compares it and moves it.
module lmrt_cell import lmrt_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     left,
  input  entry_t     right,
  input  entry_t     fresh,
  output entry_t     data,
  output logic       match
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LEFT:  data <= left;
      OP_RIGHT: data <= right;
      OP_NEW:   data <= fresh;
      default:  data <= data;
    endcase
  end

  assign match = (data.id == ctrl.key);

endmodule

// File: rtl/core/lru_module_recency_tracker_unit.sv
// The accepted input word is captured first; the result word is then registered from it once the output is free.
// Each input word is carried out to completion before the next is taken; a query with high pressure
// streams one candidate word per cycle for each held entry, least recent first, while the output is not stalled.
// The chain of cells updates with a parallel id compare, then a one-step shift.
// Reset (rst, synchronous) empties the table, clears the unload count and sets the
// pressure threshold to 85 percent; the entry storage itself is not cleared.
module lru_module_recency_tracker_unit import lmrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [PCT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [ID_W-1:0]   module_id,
  input  logic [SIZE_W-1:0] size_mb,
  input  logic [MEM_W-1:0]  total_kb,
  input  logic [MEM_W-1:0]  avail_kb,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ID_W-1:0]   entry_id,
  output logic [SIZE_W-1:0] entry_size_mb,
  output logic              found,
  output logic              full_reject,
  output logic              is_candidate,
  output logic              last,
  output logic [CNT_W-1:0]  occupancy,
  output logic [MEM_W-1:0]  unload_total
);

  // Control state.
  state_t             state, state_next;
  logic [PCT_W-1:0]   hp_percent;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [MEM_W-1:0]   unload_counter, unload_counter_next;
  logic [IDX_W-1:0]   qidx, qidx_next;
  logic               out_valid_next;

  // The captured input word.
  mode_t              mode_q;
  logic [ID_W-1:0]    key_q;
  logic [SIZE_W-1:0]  size_q;
  logic [MEM_W-1:0]   total_q;
  logic [MEM_W-1:0]   avail_q;

  // Output word register and its next value.
  logic [ID_W-1:0]    out_id_next;
  logic [SIZE_W-1:0]  out_size_next;
  logic               out_found_next, out_reject_next, out_cand_next, out_last_next;
  logic               emit;

  // Chain signals.
  cell_ctrl_t         cell_ctrl [CAPACITY];
  cell_op_t           cell_op   [CAPACITY];
  entry_t             cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] upto;   // slot is at or in front of the matching slot
  logic [CAPACITY-1:0] from;   // slot is at or behind the matching slot
  logic               hit;
  logic [SIZE_W-1:0]  hit_size;
  entry_t             fresh;

  // Pressure check: one 32x7 product on each side, then a compare.
  logic [PCT_W-1:0]   thr_sat;
  logic [PROD_W-1:0]  avail_scaled, total_scaled;
  logic               pressure_high;

  logic               in_fire, out_fire, out_load, table_full;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  // The output register can take a new word when it is empty or being drained now.
  assign out_load = !out_valid || !out_stall;
  assign table_full = (entry_count == CNT_W'(CAPACITY));

  always_comb begin
    thr_sat      = (hp_percent > PCT_FULL) ? PCT_FULL : hp_percent;
    avail_scaled = PROD_W'(avail_q) * PROD_W'(PCT_FULL);
    total_scaled = PROD_W'(total_q) * PROD_W'(PCT_FULL - thr_sat);
    pressure_high = (total_q != '0) && (avail_scaled <= total_scaled);
  end

  // The chain of cells. Each slot takes its left or right neighbor, a fresh
  // entry, or holds; the tail slot's right input is simply itself.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    entry_t left_in, right_in;
    if (i == 0) begin : g_head
      assign left_in = fresh;
    end else begin : g_body
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = cell_data[i];
    end else begin : g_inner
      assign right_in = cell_data[i+1];
    end

    assign cell_ctrl[i].op  = cell_op[i];
    assign cell_ctrl[i].key = key_q;

    lmrt_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl[i]),
      .left  (left_in),
      .right (right_in),
      .fresh (fresh),
      .data  (cell_data[i]),
      .match (cell_match[i])
    );

    // Only slots below the fill count hold live entries.
    assign hit_vec[i] = cell_match[i] && (CNT_W'(i) < entry_count);
    assign upto[i]    = |(hit_vec >> i);
    assign from[i]    = |(CAPACITY'(hit_vec << (CAPACITY - 1 - i)));
  end

  assign hit = |hit_vec;

  // Ids in the table are unique, so at most one slot matches.
  always_comb begin
    hit_size = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_size = hit_size | (hit_vec[i] ? cell_data[i].size : '0);
    end
  end

  always_comb begin
    fresh.id   = key_q;
    fresh.size = (mode_q == MODE_LOAD) ? size_q : hit_size;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_load) begin
          if (mode_q == MODE_QUERY && pressure_high && entry_count != '0) begin
            state_next = ST_QUERY;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_QUERY: begin
        if (out_load && qidx == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Cell commands, table bookkeeping and the next output word.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = OP_HOLD;
    end
    entry_count_next    = entry_count;
    unload_counter_next = unload_counter;
    qidx_next           = qidx;
    emit                = 1'b0;
    out_id_next         = key_q;
    out_size_next       = '0;
    out_found_next      = 1'b0;
    out_reject_next     = 1'b0;
    out_cand_next       = 1'b0;
    out_last_next       = 1'b1;

    case (state)
      ST_EXEC: begin
        if (out_load) begin
          case (mode_q)
            MODE_LOAD: begin
              emit = 1'b1;
              if (hit) begin
                // Refresh: move to the front with the new size.
                for (int i = 0; i < CAPACITY; i++) begin
                  if (upto[i]) cell_op[i] = (i == 0) ? OP_NEW : OP_LEFT;
                end
                out_size_next  = size_q;
                out_found_next = 1'b1;
              end else if (table_full) begin
                out_reject_next = 1'b1;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  cell_op[i] = (i == 0) ? OP_NEW : OP_LEFT;
                end
                entry_count_next = entry_count + CNT_W'(1);
                out_size_next    = size_q;
              end
            end
            MODE_UNLOAD: begin
              emit = 1'b1;
              if (hit) begin
                // Close the gap: everything behind the entry moves up one slot.
                for (int i = 0; i < CAPACITY; i++) begin
                  if (from[i]) cell_op[i] = OP_RIGHT;
                end
                entry_count_next    = entry_count - CNT_W'(1);
                unload_counter_next = unload_counter + MEM_W'(1);
                out_size_next       = hit_size;
                out_found_next      = 1'b1;
              end
            end
            MODE_TOUCH: begin
              emit = 1'b1;
              if (hit) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (upto[i]) cell_op[i] = (i == 0) ? OP_NEW : OP_LEFT;
                end
                out_size_next  = hit_size;
                out_found_next = 1'b1;
              end
            end
            MODE_QUERY: begin
              if (pressure_high && entry_count != '0) begin
                // Walk from the least recent slot toward the front.
                qidx_next = IDX_W'(entry_count - CNT_W'(1));
              end else begin
                emit        = 1'b1;
                out_id_next = '0;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      ST_QUERY: begin
        if (out_load) begin
          emit          = 1'b1;
          out_id_next   = cell_data[qidx].id;
          out_size_next = cell_data[qidx].size;
          out_cand_next = 1'b1;
          out_last_next = (qidx == '0);
          qidx_next     = qidx - IDX_W'(1);
        end
      end
      default: emit = 1'b0;
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_fire) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      hp_percent     <= PCT_RESET;
      entry_count    <= '0;
      unload_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      entry_count    <= entry_count_next;
      unload_counter <= unload_counter_next;
      out_valid      <= out_valid_next;
      if (cfg_wr_en) begin
        hp_percent <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    qidx <= qidx_next;
    if (in_fire) begin
      mode_q  <= mode_t'(mode);
      key_q   <= module_id;
      size_q  <= size_mb;
      total_q <= total_kb;
      avail_q <= avail_kb;
    end
    if (emit) begin
      entry_id      <= out_id_next;
      entry_size_mb <= out_size_next;
      found         <= out_found_next;
      full_reject   <= out_reject_next;
      is_candidate  <= out_cand_next;
      last          <= out_last_next;
      occupancy     <= entry_count_next;
      unload_total  <= unload_counter_next;
    end
  end

`ifndef SYNTHESIS
  // The fill count never runs past the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Candidate streaming only runs over a non-empty table.
  a_query_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUERY) |-> (entry_count != '0))
    else $error("query walk over empty table");

  // An accepted word always puts the block in the execute state in the following cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_EXEC))
    else $error("accepted word not executed");

  // The unload count only ever steps up by one.
  a_unload_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && unload_counter != $past(unload_counter)) |->
      (unload_counter == $past(unload_counter) + MEM_W'(1)))
    else $error("unload count jumped");
`endif

endmodule

// File: tb/lmrt_tb_pkg.sv
// Scoreboard class that predicts and checks the result words of the recency tracker.
package lmrt_tb_pkg;
  import lmrt_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size_mb;
    logic              found;
    logic              full_reject;
    logic              is_candidate;
    logic              last;
    logic [CNT_W-1:0]  occupancy;
    logic [MEM_W-1:0]  unload_total;
  } tracker_word_t;

  class recency_scoreboard;
    logic [ID_W-1:0]   ids [CAPACITY];
    logic [SIZE_W-1:0] sizes [CAPACITY];
    int                held;
    logic [MEM_W-1:0]  unloads;
    logic [PCT_W-1:0]  percent;
    tracker_word_t     pending [$];
    int                mismatches;
    int                words_checked;
    int                candidate_words;
    int                reject_words;
    int                hit_words;

    function new();
      held = 0;
      unloads = '0;
      percent = PCT_RESET;
      mismatches = 0;
      words_checked = 0;
      candidate_words = 0;
      reject_words = 0;
      hit_words = 0;
    endfunction

    function void set_percent(logic [PCT_W-1:0] value);
      percent = value;
    endfunction

    // Exact integer form of the usage ratio; a zero total never counts as pressure.
    function bit pressure_high(logic [MEM_W-1:0] total_kb, logic [MEM_W-1:0] avail_kb);
      logic [63:0] thr;
      thr = (percent > PCT_FULL) ? 64'(PCT_FULL) : 64'(percent);
      if (total_kb == '0) return 1'b0;
      return (64'd100 * 64'(avail_kb)) <= ((64'd100 - thr) * 64'(total_kb));
    endfunction

    function int slot_of(logic [ID_W-1:0] key);
      for (int i = 0; i < held; i++)
        if (ids[i] == key) return i;
      return -1;
    endfunction

    function void drop_slot(int pos);
      for (int i = pos; i + 1 < held; i++) begin
        ids[i] = ids[i + 1];
        sizes[i] = sizes[i + 1];
      end
      held--;
    endfunction

    function void insert_front(logic [ID_W-1:0] key, logic [SIZE_W-1:0] sz);
      for (int i = held; i > 0; i--) begin
        ids[i] = ids[i - 1];
        sizes[i] = sizes[i - 1];
      end
      ids[0] = key;
      sizes[0] = sz;
      held++;
    endfunction

    function void queue_result(tracker_word_t w);
      w.occupancy = CNT_W'(held);
      w.unload_total = unloads;
      pending = {pending, w};
    endfunction

    // Applies one accepted input word to the shadow table and queues its results.
    function void note_word(mode_t op, logic [ID_W-1:0] key, logic [SIZE_W-1:0] sz,
                            logic [MEM_W-1:0] total_kb, logic [MEM_W-1:0] avail_kb);
      tracker_word_t w;
      int pos;
      logic [SIZE_W-1:0] old_size;
      w = '0;
      w.last = 1'b1;
      w.id = key;
      if (op == MODE_QUERY) begin
        w.id = '0;
        if (!pressure_high(total_kb, avail_kb) || held == 0) begin
          queue_result(w);
          return;
        end
        for (int i = held - 1; i >= 0; i--) begin
          w.id = ids[i];
          w.size_mb = sizes[i];
          w.is_candidate = 1'b1;
          w.last = (i == 0);
          queue_result(w);
        end
        return;
      end
      pos = slot_of(key);
      if (op == MODE_LOAD) begin
        if (pos >= 0) begin
          drop_slot(pos);
          insert_front(key, sz);
          w.found = 1'b1;
          w.size_mb = sz;
        end else if (held >= CAPACITY) begin
          w.full_reject = 1'b1;
        end else begin
          insert_front(key, sz);
          w.size_mb = sz;
        end
      end else if (pos >= 0) begin
        old_size = sizes[pos];
        drop_slot(pos);
        if (op == MODE_UNLOAD) unloads++;
        else insert_front(key, old_size);
        w.found = 1'b1;
        w.size_mb = old_size;
      end
      queue_result(w);
    endfunction

    function string show(tracker_word_t w);
      return $sformatf("id %h size %h found %b reject %b cand %b last %b occ %0d unloads %0d",
                       w.id, w.size_mb, w.found, w.full_reject, w.is_candidate, w.last,
                       w.occupancy, w.unload_total);
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_word(tracker_word_t got);
      tracker_word_t want;
      words_checked++;
      if (got.is_candidate === 1'b1) candidate_words++;
      if (got.full_reject === 1'b1) reject_words++;
      if (got.found === 1'b1) hit_words++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %s", show(got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result word %0d", words_checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

// File: tb/tb_lru_module_recency_tracker_unit.sv
// Self-checking testbench for the module recency tracker with random stalls and thresholds.
module tb_lru_module_recency_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lmrt_pkg::*;
  import lmrt_tb_pkg::*;

  // The run length guard is far above the slowest legal run: every word waiting out
  // long receiver stalls, every query streaming a full table.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 420;
  localparam int PHASES       = 5;
  localparam int ID_POOL      = 24;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [PCT_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode = MODE_LOAD;
  logic [ID_W-1:0]   module_id = '0;
  logic [SIZE_W-1:0] size_mb = '0;
  logic [MEM_W-1:0]  total_kb = '0;
  logic [MEM_W-1:0]  avail_kb = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ID_W-1:0]   entry_id;
  logic [SIZE_W-1:0] entry_size_mb;
  logic              found;
  logic              full_reject;
  logic              is_candidate;
  logic              last;
  logic [CNT_W-1:0]  occupancy;
  logic [MEM_W-1:0]  unload_total;

  recency_scoreboard board;
  logic [ID_W-1:0]   id_pool [ID_POOL];
  int                cycle_count = 0;
  int                items_sent = 0;
  int                settings_used = 1;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  int                rx_calm_left = 0;
  int                hold_left = 0;
  bit                long_hold_done = 1'b0;
  int                rx_roll;

  lru_module_recency_tracker_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .module_id     (module_id),
    .size_mb       (size_mb),
    .total_kb      (total_kb),
    .avail_kb      (avail_kb),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .entry_id      (entry_id),
    .entry_size_mb (entry_size_mb),
    .found         (found),
    .full_reject   (full_reject),
    .is_candidate  (is_candidate),
    .last          (last),
    .occupancy     (occupancy),
    .unload_total  (unload_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost word ends the run here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d words still expected.",
               cycle_count, board.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver side. Stall changes only on the falling edge. Calm stretches leave the
  // output free, short random stalls and occasional longer hold-offs fall in between.
  // Once, after enough words have arrived, the receiver holds off for a long stretch
  // while the sender keeps offering, so the block backs up and stalls its input.
  always @(negedge clk) begin
    if (rx_calm_left == 0) begin
      rx_calm = ($urandom_range(0, 3) == 0);
      rx_calm_left = $urandom_range(20, 80);
    end else begin
      rx_calm_left--;
    end
    if (!long_hold_done && board != null && board.words_checked >= 150) begin
      hold_left = 120;
      long_hold_done = 1'b1;
    end
    rx_roll = $urandom_range(0, 99);
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (rx_calm) begin
      out_stall = 1'b0;
    end else if (rx_roll < 2) begin
      hold_left = $urandom_range(5, 30);
      out_stall = 1'b1;
    end else begin
      out_stall = (rx_roll < 30);
    end
  end

  // A result word is taken at every rising edge with valid high and stall low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_word(tracker_word_t'{entry_id, entry_size_mb, found, full_reject,
                                       is_candidate, last, occupancy, unload_total});
  end

  // Offers one input word after a random gap and returns on the falling edge after it
  // was accepted. Valid stays high on return so back-to-back words need no idle cycle.
  task automatic send_word(mode_t op, logic [ID_W-1:0] key, logic [SIZE_W-1:0] sz,
                           logic [MEM_W-1:0] total, logic [MEM_W-1:0] avail);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_calm || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 25);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    mode = op;
    module_id = key;
    size_mb = sz;
    total_kb = total;
    avail_kb = avail;
    do @(posedge clk); while (in_stall);
    board.note_word(op, key, sz, total, avail);
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected word has come back, then lets the pipeline settle
  // so a threshold write never lands on a busy block.
  task automatic drain_results();
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_percent(logic [PCT_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.set_percent(value);
    settings_used++;
  endtask

  // One random word. Ids mostly come from a small pool so that hits, refreshes and a
  // full table are common; the memory figures are spread around the pressure threshold,
  // with zero totals, availability above total and exact boundary cases mixed in.
  task automatic random_item(int load_share);
    int roll;
    int pick;
    mode_t op;
    logic [ID_W-1:0] key;
    logic [SIZE_W-1:0] sz;
    logic [MEM_W-1:0] total;
    logic [MEM_W-1:0] avail;
    logic [63:0] thr;
    roll = $urandom_range(0, 99);
    if (roll < load_share) op = MODE_LOAD;
    else if (roll < load_share + 20) op = MODE_UNLOAD;
    else if (roll < load_share + 45) op = MODE_TOUCH;
    else op = MODE_QUERY;
    key = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, ID_POOL - 1)];
    pick = $urandom_range(0, 9);
    sz = (pick == 0) ? '0 : (pick == 1) ? '1 : SIZE_W'($urandom);
    total = $urandom;
    avail = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0: total = '0;
      1: avail = (total == '1) ? total : total + MEM_W'($urandom_range(1, 1000));
      2: begin
        total = '1;
        avail = '0;
      end
      3: begin
        // Lands exactly on the threshold or one above it.
        thr = (board.percent > PCT_FULL) ? 64'(PCT_FULL) : 64'(board.percent);
        total = MEM_W'($urandom_range(1, 42_949_672)) * MEM_W'(100);
        avail = MEM_W'(64'(total) / 64'd100 * (64'd100 - thr)) + MEM_W'($urandom_range(0, 1));
      end
      4: ;
      default: avail = MEM_W'((64'(total) * 64'($urandom_range(0, 100))) / 64'd100);
    endcase
    send_word(op, key, sz, total, avail);
  endtask

  initial begin
    logic [PCT_W-1:0] phase_pct [PHASES];
    int               phase_loads [PHASES];
    board = new();
    for (int i = 0; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom);
    phase_pct = '{PCT_W'(0), PCT_FULL, PCT_W'(127), PCT_W'(60), PCT_W'($urandom_range(0, 127))};
    phase_loads = '{40, 15, 45, 30, 40};

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset threshold of 85 percent. A query on an empty table
    // under high pressure, unload and touch of an absent id, then a full table.
    send_word(MODE_QUERY, 16'h0000, '0, 32'd1000, 32'd0);
    send_word(MODE_UNLOAD, 16'h1234, '0, '0, '0);
    send_word(MODE_TOUCH, 16'h1234, '0, '0, '0);
    for (int i = 0; i < CAPACITY; i++)
      send_word(MODE_LOAD, ID_W'(i * 16'h1111),
                (i == 0) ? '0 : (i == CAPACITY - 1) ? '1 : SIZE_W'($urandom), '0, '0);
    // A new id into the full table is refused; reloading a held id is not.
    send_word(MODE_LOAD, 16'hABCD, SIZE_W'(5), '0, '0);
    send_word(MODE_LOAD, 16'h3333, SIZE_W'(7), '0, '0);
    // Low pressure with a zero total and with availability above total, then a query
    // sitting exactly on the threshold, which streams the whole table.
    send_word(MODE_QUERY, 16'hFFFF, '1, '0, '0);
    send_word(MODE_QUERY, 16'h0000, '0, 32'd100, 32'd200);
    send_word(MODE_QUERY, 16'h0000, '0, 32'd100, 32'd15);
    send_word(MODE_TOUCH, 16'h0000, '0, '0, '0);
    send_word(MODE_UNLOAD, 16'hFFFF, '0, '0, '0);
    drain_results();

    // Random phases, each under its own threshold: zero, exactly full, above full,
    // a middle value and a random one. Load share varies so the table fills and drains.
    for (int p = 0; p < PHASES; p++) begin
      write_percent(phase_pct[p]);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 50 == 0) tx_calm = ($urandom_range(0, 2) == 0);
        random_item(phase_loads[p]);
      end
      drain_results();
    end

    $display("Sent %0d input words under %0d threshold settings, including a long output hold-off.",
             items_sent, settings_used);
    $display("Checked %0d result words: %0d candidates, %0d full-table refusals, %0d hits.",
             board.words_checked, board.candidate_words, board.reject_words, board.hit_words);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatching words, %0d words never arrived.",
               board.mismatches, board.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
